// ===== hdl/fcb_pkg.sv =====
// Shared types, constants and register codes for the frame cross-fade blender.
// Used by every module of the block but fcb_ram; depends on nothing else.
`timescale 1ns / 1ps

package fcb_pkg;

  // Default frame store geometry.
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // Full-scale blend weight.
  localparam int MIX_MAX = 100;

  // Field and register widths.
  localparam int CH_W   = 8;
  localparam int POS_W  = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int PW_W   = 9;
  localparam int PH_W   = 9;
  localparam int SRL_W  = 13;
  localparam int OW_W   = 7;
  localparam int WT_W   = 8;
  localparam int CNT_W  = 12;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // APB register file.
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 4;
  localparam int IDX_W   = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_PANEL_WIDTH   = 2'd0,
    REG_PANEL_HEIGHT  = 2'd1,
    REG_SRC_ROW_LEN   = 2'd2,
    REG_OLD_WEIGHT    = 2'd3
  } reg_idx_t;

  localparam logic [PW_W-1:0]  PANEL_WIDTH_RST  = 9'd64;
  localparam logic [PH_W-1:0]  PANEL_HEIGHT_RST = 9'd32;
  localparam logic [SRL_W-1:0] SRC_ROW_LEN_RST  = 13'd64;
  localparam logic [OW_W-1:0]  OLD_WEIGHT_RST   = 7'd0;

  // Blend sum width and the exact reciprocal used to divide it by MIX_MAX.
  localparam int SUM_W   = $clog2((1 << CH_W) * MIX_MAX);
  localparam int QSH     = SUM_W + $clog2(MIX_MAX);
  localparam int RECIP_W = SUM_W + 1;
  localparam longint RECIP = ((longint'(1) << QSH) + MIX_MAX - 1) / MIX_MAX;

  // Result words buffered ahead of the output port.
  localparam int OUT_DEPTH = 4;

  typedef struct packed {
    logic [PW_W-1:0]  panel_width;
    logic [PH_W-1:0]  panel_height;
    logic [SRL_W-1:0] source_row_length;
    logic [OW_W-1:0]  old_weight;
  } cfg_t;

  typedef struct packed {
    logic            start_of_frame;
    logic            first_frame;
    logic [CH_W-1:0] src_blue;
    logic [CH_W-1:0] src_green;
    logic [CH_W-1:0] src_red;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0] pixel_column;
    logic [POS_W-1:0] pixel_row;
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
    logic             frame_done;
  } out_word_t;

  // Position decode handed from the counter stage to the blend pipeline.
  typedef struct packed {
    logic             kept;
    logic [WT_W-1:0]  weight;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             done;
  } pos_info_t;

endpackage

// ===== hdl/fcb_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; read during a write to the same entry returns the old data.
`timescale 1ns / 1ps

module fcb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/fcb_pos.sv =====
// Column and row tracking, window test, store address and weight selection.
// Depends on fcb_pkg.
`timescale 1ns / 1ps

module fcb_pos #(
  parameter int MAX_WIDTH  = fcb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fcb_pkg::MAX_HEIGHT_DEF,
  localparam int ADDR_W = (MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                sof,
  input  logic                first,
  input  fcb_pkg::cfg_t       cfg,
  output fcb_pkg::pos_info_t  info,
  output logic [ADDR_W-1:0]   addr
);

  localparam int CW  = fcb_pkg::CNT_W;
  localparam int SW  = fcb_pkg::SRL_W;
  localparam int PWW = fcb_pkg::PW_W;
  localparam int PHW = fcb_pkg::PH_W;
  localparam int AXW = PWW + PHW + 1;

  logic [CW-1:0]  col_r, col_nxt, row_r, row_nxt;
  logic [CW-1:0]  col_cur, row_cur;
  logic [PWW-1:0] kw;
  logic [PHW-1:0] kh;
  logic [SW-1:0]  col_inc, row_inc;
  logic           wrap;
  logic [AXW-1:0] addr_full;

  always_comb begin
    col_cur = sof ? '0 : col_r;
    row_cur = sof ? '0 : row_r;

    if (SW'(cfg.panel_width) < SW'(MAX_WIDTH)) begin
      kw = cfg.panel_width;
    end else begin
      kw = PWW'(MAX_WIDTH);
    end
    if (SW'(cfg.panel_height) < SW'(MAX_HEIGHT)) begin
      kh = cfg.panel_height;
    end else begin
      kh = PHW'(MAX_HEIGHT);
    end

    col_inc = SW'(col_cur) + SW'(1);
    row_inc = SW'(row_cur) + SW'(1);

    info.kept = (SW'(col_cur) < SW'(kw)) && (SW'(row_cur) < SW'(kh));
    info.col  = col_cur[fcb_pkg::POS_W-1:0];
    info.row  = row_cur[fcb_pkg::POS_W-1:0];
    info.done = (col_inc == SW'(kw)) && (row_inc == SW'(kh));

    if (first) begin
      info.weight = '0;
    end else if ({1'b0, cfg.old_weight} > fcb_pkg::WT_W'(fcb_pkg::MIX_MAX)) begin
      info.weight = fcb_pkg::WT_W'(fcb_pkg::MIX_MAX);
    end else begin
      info.weight = {1'b0, cfg.old_weight};
    end

    // Only meaningful inside the window, where the row fits the height field.
    addr_full = AXW'(AXW'(row_cur[PHW-1:0]) * AXW'(kw)) + AXW'(col_cur[PWW-1:0]);
    addr      = ADDR_W'(addr_full);

    wrap = (col_inc >= cfg.source_row_length) || (col_cur == fcb_pkg::CNT_MAX);
    if (wrap) begin
      col_nxt = '0;
      row_nxt = (row_cur == fcb_pkg::CNT_MAX) ? row_cur : row_inc[CW-1:0];
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== hdl/fcb_blend.sv =====
// Read-modify-write pipeline: forwards the latest store write, forms the
// weighted sums, divides by the full-scale weight and writes back. Depends on fcb_pkg.
`timescale 1ns / 1ps

module fcb_blend #(
  parameter int ADDR_W = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take,
  input  fcb_pkg::pos_info_t            info,
  input  logic [ADDR_W-1:0]             addr,
  input  logic [fcb_pkg::PIX_W-1:0]     new_pix,
  input  logic [fcb_pkg::PIX_W-1:0]     rd_data,
  output logic                          wr_en,
  output logic [ADDR_W-1:0]             wr_addr,
  output logic [fcb_pkg::PIX_W-1:0]     wr_data,
  output fcb_pkg::out_word_t            res,
  output logic                          s1_valid,
  output logic [ADDR_W-1:0]             s1_addr,
  output logic                          s2_valid
);

  localparam int CH  = fcb_pkg::CH_W;
  localparam int PX  = fcb_pkg::PIX_W;
  localparam int SUW = fcb_pkg::SUM_W;
  localparam int PRW = fcb_pkg::SUM_W + fcb_pkg::RECIP_W;
  localparam int MW  = 2 * CH;

  localparam logic [fcb_pkg::RECIP_W-1:0] RECIP_C = fcb_pkg::RECIP_W'(fcb_pkg::RECIP);

  // Stage 1: store data arrives.
  logic                s1_v_r;
  logic [ADDR_W-1:0]   s1_addr_r;
  fcb_pkg::pos_info_t  s1_info_r;
  logic [PX-1:0]       s1_new_r;

  // Stage 2: weighted sums.
  logic                s2_v_r;
  logic [ADDR_W-1:0]   s2_addr_r;
  fcb_pkg::pos_info_t  s2_info_r;
  logic [SUW-1:0]      s2_sum_r [3];

  // Last word written to the store, for a read that raced the write.
  logic                fwd_v_r;
  logic [ADDR_W-1:0]   fwd_addr_r;
  logic [PX-1:0]       fwd_data_r;

  logic [PX-1:0]       old_pix;
  logic [PX-1:0]       old_used;
  logic [fcb_pkg::WT_W-1:0] new_wt;
  logic [SUW-1:0]      sum_nxt [3];
  logic [PX-1:0]       blended;

  always_comb begin
    old_pix = (fwd_v_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : rd_data;
    // With no weight on the stored pixel its entry may never have been written,
    // so it is kept out of the sum altogether.
    old_used = (s1_info_r.weight == '0) ? '0 : old_pix;
    new_wt  = fcb_pkg::WT_W'(fcb_pkg::MIX_MAX) - s1_info_r.weight;
    for (int c = 0; c < 3; c++) begin
      sum_nxt[c] = SUW'((MW + 1)'(MW'(old_used[c*CH +: CH]) * MW'(s1_info_r.weight))
                      + (MW + 1)'(MW'(s1_new_r[c*CH +: CH]) * MW'(new_wt)));
    end
  end

  // Exact division by the full-scale weight through a reciprocal multiply.
  always_comb begin
    logic [PRW-1:0] prod;
    for (int c = 0; c < 3; c++) begin
      prod = PRW'(s2_sum_r[c]) * PRW'(RECIP_C);
      blended[c*CH +: CH] = prod[fcb_pkg::QSH +: CH];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      s1_v_r <= take;
      s2_v_r <= s1_v_r;
      if (s2_v_r) begin
        fwd_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= addr;
    s1_info_r <= info;
    s1_new_r  <= new_pix;
    s2_addr_r <= s1_addr_r;
    s2_info_r <= s1_info_r;
    for (int c = 0; c < 3; c++) begin
      s2_sum_r[c] <= sum_nxt[c];
    end
    if (s2_v_r) begin
      fwd_addr_r <= s2_addr_r;
      fwd_data_r <= blended;
    end
  end

  assign wr_en   = s2_v_r;
  assign wr_addr = s2_addr_r;
  assign wr_data = blended;

  assign res.pixel_column = s2_info_r.col;
  assign res.pixel_row    = s2_info_r.row;
  assign res.out_red      = blended[2*CH +: CH];
  assign res.out_green    = blended[CH +: CH];
  assign res.out_blue     = blended[0 +: CH];
  assign res.frame_done   = s2_info_r.done;

  assign s1_valid = s1_v_r;
  assign s1_addr  = s1_addr_r;
  assign s2_valid = s2_v_r;

endmodule

// ===== hdl/fcb_fifo.sv =====
// Small result buffer between the blend pipeline and the output port.
// Depends on fcb_pkg for the result word type.
`timescale 1ns / 1ps

module fcb_fifo #(
  parameter int DEPTH = fcb_pkg::OUT_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fcb_pkg::out_word_t push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output fcb_pkg::out_word_t pop_data,
  output logic [CNT_W-1:0]   count
);

  fcb_pkg::out_word_t mem_r [DEPTH];
  logic [PTR_W-1:0]   wp_r, rp_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rp_r];
  assign count     = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

// ===== hdl/frame_crossfade_blender.sv =====
// Frame cross-fade blender: configuration registers, input handshake and the
// store. Depends on fcb_pkg, fcb_pos, fcb_blend, fcb_fifo and fcb_ram.
//
// Use: source pixels enter on the in_ channel (valid/ready) in raster order;
// each word carries the start-of-frame and first-frame flags and the blue,
// green and red bytes. Pixels inside the panel window are blended with the
// stored pixel of the previous frame, written back and sent on the out_
// channel with their column, row and an end-of-frame mark; the rest are dropped.
// Throughput is one pixel per clock while in_ready is high. A pixel that hits the
// same store entry as the pixel just before it (a repeated start of frame) waits
// while that pixel is in stage 1, since the store is read before the blended word
// is written back. A kept word passes stage 1 (store data) and stage 2 (weighted
// sums) and is then pushed into the result buffer, which raises out_valid.
// A four-word result buffer lets input continue while the receiver stalls;
// in_ready falls once the buffer and the pipeline together hold four words.
// Reset clears the counters, the pipeline and the buffer and loads the register
// defaults; the frame store is not cleared, so the first frame must use the
// first-frame flag. Registers sit on the APB port at byte offsets 0, 4, 8, 12.
`timescale 1ns / 1ps

module frame_crossfade_blender #(
  parameter int MAX_WIDTH  = fcb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fcb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fcb_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output fcb_pkg::out_word_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcb_pkg::PADDR_W-1:0]   paddr,
  input  logic [fcb_pkg::DATA_W-1:0]    pwdata,
  output logic [fcb_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QD     = fcb_pkg::OUT_DEPTH;
  localparam int QCW    = $clog2(QD + 1);
  localparam int CRW    = QCW + 1;

  // Configuration registers.
  fcb_pkg::cfg_t     cfg_r;
  fcb_pkg::reg_idx_t reg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = fcb_pkg::reg_idx_t'(paddr[fcb_pkg::IDX_W+1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.panel_width       <= fcb_pkg::PANEL_WIDTH_RST;
      cfg_r.panel_height      <= fcb_pkg::PANEL_HEIGHT_RST;
      cfg_r.source_row_length <= fcb_pkg::SRC_ROW_LEN_RST;
      cfg_r.old_weight        <= fcb_pkg::OLD_WEIGHT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        fcb_pkg::REG_PANEL_WIDTH: begin
          cfg_r.panel_width <= pwdata[fcb_pkg::PW_W-1:0];
        end
        fcb_pkg::REG_PANEL_HEIGHT: begin
          cfg_r.panel_height <= pwdata[fcb_pkg::PH_W-1:0];
        end
        fcb_pkg::REG_SRC_ROW_LEN: begin
          cfg_r.source_row_length <= pwdata[fcb_pkg::SRL_W-1:0];
        end
        fcb_pkg::REG_OLD_WEIGHT: begin
          cfg_r.old_weight <= pwdata[fcb_pkg::OW_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fcb_pkg::REG_PANEL_WIDTH:  prdata = fcb_pkg::DATA_W'(cfg_r.panel_width);
      fcb_pkg::REG_PANEL_HEIGHT: prdata = fcb_pkg::DATA_W'(cfg_r.panel_height);
      fcb_pkg::REG_SRC_ROW_LEN:  prdata = fcb_pkg::DATA_W'(cfg_r.source_row_length);
      fcb_pkg::REG_OLD_WEIGHT:   prdata = fcb_pkg::DATA_W'(cfg_r.old_weight);
      default:                   prdata = '0;
    endcase
  end

  // Datapath.
  fcb_pkg::pos_info_t        info;
  logic [ADDR_W-1:0]         addr;
  logic                      accept;
  logic                      take;
  logic                      hazard;
  logic                      room;
  logic [fcb_pkg::PIX_W-1:0] rd_data, wr_data;
  logic                      wr_en;
  logic [ADDR_W-1:0]         wr_addr;
  fcb_pkg::out_word_t        res;
  logic                      s1_valid, s2_valid;
  logic [ADDR_W-1:0]         s1_addr;
  logic [QCW-1:0]            q_count;

  // Every word in flight has a buffer place reserved for it.
  assign room   = (CRW'(q_count) + CRW'(s1_valid) + CRW'(s2_valid)) < CRW'(QD);
  assign hazard = info.kept && s1_valid && (s1_addr == addr);
  assign in_ready = room && !hazard;
  assign accept = in_valid && in_ready;
  assign take   = accept && info.kept;

  fcb_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .sof    (in_data.start_of_frame),
    .first  (in_data.first_frame),
    .cfg    (cfg_r),
    .info   (info),
    .addr   (addr)
  );

  fcb_ram #(
    .WIDTH (fcb_pkg::PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (take),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  fcb_blend #(
    .ADDR_W (ADDR_W)
  ) u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .info     (info),
    .addr     (addr),
    .new_pix  ({in_data.src_red, in_data.src_green, in_data.src_blue}),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .res      (res),
    .s1_valid (s1_valid),
    .s1_addr  (s1_addr),
    .s2_valid (s2_valid)
  );

  fcb_fifo #(
    .DEPTH (QD)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (wr_en),
    .push_data (res),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_data  (out_data),
    .count     (q_count)
  );

  // The reservation scheme must keep the buffer from overflowing.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (CRW'(q_count) + CRW'(s1_valid) + CRW'(s2_valid)) <= CRW'(QD))
    else $error("result buffer over-committed");

  // Two words in flight never share a store entry, so forwarding one write suffices.
  a_no_adjacent_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && s2_valid) |-> (s1_addr != wr_addr))
    else $error("adjacent pipeline words target the same store entry");

  // A kept word passes stage 1 and reaches the write-back stage with no stall between.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> ##1 wr_en)
    else $error("kept word did not reach the write-back stage");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the frame cross-fade blender: raster pixel words in,
// blended panel words out, registers written over the APB port between phases.
// Depends on fcb_pkg and frame_crossfade_blender.
`timescale 1ns / 1ps

module tb_top;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  localparam int LONG_STALL   = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int STORE_DEPTH  = fcb_pkg::MAX_WIDTH_DEF * fcb_pkg::MAX_HEIGHT_DEF;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  fcb_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fcb_pkg::out_word_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [fcb_pkg::PADDR_W-1:0] paddr = '0;
  logic [fcb_pkg::DATA_W-1:0] pwdata = '0;
  logic [fcb_pkg::DATA_W-1:0] prdata;
  logic pready;

  // Predicted block state: registers, position counters and the frame store.
  fcb_pkg::cfg_t fade_cfg = '{fcb_pkg::PANEL_WIDTH_RST, fcb_pkg::PANEL_HEIGHT_RST,
                              fcb_pkg::SRC_ROW_LEN_RST, fcb_pkg::OLD_WEIGHT_RST};
  logic [fcb_pkg::CNT_W-1:0] col_cnt = '0;
  logic [fcb_pkg::CNT_W-1:0] row_cnt = '0;
  logic [fcb_pkg::PIX_W-1:0] fade_store [STORE_DEPTH];
  bit fade_written [STORE_DEPTH];
  fcb_pkg::out_word_t pending_pixels [$];
  int unsigned fade_count = 0;

  int err_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int noise_pct = 0;
  logic stall_req = 1'b0;
  logic stall_ack = 1'b0;
  int stall_left = 0;

  frame_crossfade_blender uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [fcb_pkg::CH_W-1:0] mix_channel(input int unsigned old_v,
                                                           input int unsigned new_v,
                                                           input int unsigned w);
    return fcb_pkg::CH_W'((old_v * w + new_v * (fcb_pkg::MIX_MAX - w))
                          / fcb_pkg::MIX_MAX);
  endfunction

  // Works out the result of one pixel and advances the position counters. A kept
  // pixel whose store entry has never been written is sent as a first-frame pixel.
  function automatic void fade_pixel(inout fcb_pkg::in_word_t px);
    int unsigned kw, kh, col, row, w, addr;
    logic [fcb_pkg::PIX_W-1:0] prior;
    fcb_pkg::out_word_t res;
    if (px.start_of_frame) begin
      col_cnt = '0;
      row_cnt = '0;
    end
    col = col_cnt;
    row = row_cnt;
    kw = (fade_cfg.panel_width < fcb_pkg::MAX_WIDTH_DEF) ?
         fade_cfg.panel_width : fcb_pkg::MAX_WIDTH_DEF;
    kh = (fade_cfg.panel_height < fcb_pkg::MAX_HEIGHT_DEF) ?
         fade_cfg.panel_height : fcb_pkg::MAX_HEIGHT_DEF;
    if (col < kw && row < kh) begin
      addr = row * kw + col;
      if (!fade_written[addr]) px.first_frame = 1'b1;
      w = (fade_cfg.old_weight < fcb_pkg::MIX_MAX) ? fade_cfg.old_weight : fcb_pkg::MIX_MAX;
      if (px.first_frame) w = 0;
      prior = fade_store[addr];
      res.out_red = mix_channel(prior[23:16], px.src_red, w);
      res.out_green = mix_channel(prior[15:8], px.src_green, w);
      res.out_blue = mix_channel(prior[7:0], px.src_blue, w);
      res.pixel_column = col[fcb_pkg::POS_W-1:0];
      res.pixel_row = row[fcb_pkg::POS_W-1:0];
      res.frame_done = (col + 1 == kw) && (row + 1 == kh);
      fade_store[addr] = {res.out_red, res.out_green, res.out_blue};
      fade_written[addr] = 1'b1;
      pending_pixels.push_back(res);
      fade_count++;
    end
    if (col + 1 >= fade_cfg.source_row_length || col >= fcb_pkg::CNT_MAX) begin
      col_cnt = '0;
      if (row_cnt < fcb_pkg::CNT_MAX) row_cnt = row_cnt + 1'b1;
    end else begin
      col_cnt = fcb_pkg::CNT_W'(col + 1);
    end
  endfunction

  function automatic void check_field(input string name,
                                      input logic [fcb_pkg::CH_W-1:0] want,
                                      input logic [fcb_pkg::CH_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  task automatic check_pixel(input fcb_pkg::out_word_t got);
    fcb_pkg::out_word_t want;
    if (pending_pixels.size() == 0) begin
      $error("unexpected result word at column %0d row %0d", got.pixel_column,
             got.pixel_row);
      err_cnt++;
    end else begin
      want = pending_pixels.pop_front();
      check_field("pixel_column", want.pixel_column, got.pixel_column);
      check_field("pixel_row", want.pixel_row, got.pixel_row);
      check_field("out_red", want.out_red, got.out_red);
      check_field("out_green", want.out_green, got.out_green);
      check_field("out_blue", want.out_blue, got.out_blue);
      check_field("frame_done", want.frame_done, got.frame_done);
    end
  endtask

  // Result side: checks every accepted word and decides out_ready for the next edge.
  // A toggle of stall_req starts a long hold-off that is counted down here.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_pixel(out_data);
    if (stall_req != stall_ack) begin
      stall_ack <= stall_req;
      stall_left <= LONG_STALL;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 61;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 61;
      end
      default: begin
        send_idle_pct = 6;
        recv_stall_pct = 6;
      end
    endcase
  endtask

  // Writes one register, then reads it back.
  task automatic write_reg(input fcb_pkg::reg_idx_t idx, input int unsigned value);
    logic [fcb_pkg::DATA_W-1:0] reg_val;
    case (idx)
      fcb_pkg::REG_PANEL_WIDTH: begin
        fade_cfg.panel_width = value[fcb_pkg::PW_W-1:0];
        reg_val = fade_cfg.panel_width;
      end
      fcb_pkg::REG_PANEL_HEIGHT: begin
        fade_cfg.panel_height = value[fcb_pkg::PH_W-1:0];
        reg_val = fade_cfg.panel_height;
      end
      fcb_pkg::REG_SRC_ROW_LEN: begin
        fade_cfg.source_row_length = value[fcb_pkg::SRL_W-1:0];
        reg_val = fade_cfg.source_row_length;
      end
      default: begin
        fade_cfg.old_weight = value[fcb_pkg::OW_W-1:0];
        reg_val = fade_cfg.old_weight;
      end
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== reg_val) begin
      $error("register %s: expected %0d, got %0d", idx.name(), reg_val, prdata);
      err_cnt++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned pw, input int unsigned ph,
                            input int unsigned srl, input int unsigned ow);
    drain_results();
    write_reg(fcb_pkg::REG_PANEL_WIDTH, pw);
    write_reg(fcb_pkg::REG_PANEL_HEIGHT, ph);
    write_reg(fcb_pkg::REG_SRC_ROW_LEN, srl);
    write_reg(fcb_pkg::REG_OLD_WEIGHT, ow);
  endtask

  function automatic fcb_pkg::in_word_t make_pixel(input bit sof, input bit ff,
                                                   input logic [fcb_pkg::CH_W-1:0] b,
                                                   input logic [fcb_pkg::CH_W-1:0] g,
                                                   input logic [fcb_pkg::CH_W-1:0] r);
    fcb_pkg::in_word_t px;
    px.start_of_frame = sof;
    px.first_frame = ff;
    px.src_blue = b;
    px.src_green = g;
    px.src_red = r;
    return px;
  endfunction

  // Offers one word and returns at the edge that accepts it. in_valid stays high
  // so that a following word can go out in the very next cycle.
  task automatic send_pixel(input fcb_pkg::in_word_t px);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    fade_pixel(px);
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_frame(input int unsigned n_pix, input bit fresh);
    for (int unsigned i = 0; i < n_pix; i++) begin
      send_pixel(make_pixel((i == 0) || ($urandom_range(0, 99) < noise_pct),
                            fresh || ($urandom_range(0, 99) < noise_pct),
                            $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255)));
    end
  endtask

  task automatic directed_test();
    set_idle(IDLE_NONE);
    set_config(2, 2, 3, fcb_pkg::MIX_MAX);
    // First frame: no history, so the stored weight is ignored.
    send_pixel(make_pixel(1, 1, 8'h00, 8'hFF, 8'h00));
    send_pixel(make_pixel(0, 1, 8'hFF, 8'h00, 8'hFF));
    send_pixel(make_pixel(0, 1, 8'hAA, 8'h55, 8'hAA));
    send_pixel(make_pixel(0, 1, 8'h12, 8'h34, 8'h56));
    send_pixel(make_pixel(0, 1, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(make_pixel(0, 1, 8'h00, 8'h00, 8'h00));
    // Full weight on the stored pixel: the new bytes must not show through.
    send_pixel(make_pixel(1, 0, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(make_pixel(0, 0, 8'h00, 8'h00, 8'h00));
    // A weight above full scale saturates.
    set_config(2, 2, 3, (1 << fcb_pkg::OW_W) - 1);
    send_pixel(make_pixel(1, 0, 8'h00, 8'h00, 8'h00));
    send_pixel(make_pixel(0, 0, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(make_pixel(0, 0, 8'h5A, 8'hA5, 8'h3C));
    // Two starts of frame in a row read and write the same store entry back to back.
    set_config(2, 2, 3, 50);
    send_pixel(make_pixel(1, 0, 8'h80, 8'h01, 8'h7F));
    send_pixel(make_pixel(1, 0, 8'h01, 8'hFE, 8'h80));
    send_pixel(make_pixel(1, 0, 8'hFF, 8'h00, 8'h33));
    // With a row length of zero every pixel starts a new row.
    set_config(2, 2, 0, 37);
    send_pixel(make_pixel(1, 0, 8'h11, 8'h22, 8'h33));
    send_pixel(make_pixel(0, 0, 8'hEE, 8'hDD, 8'hCC));
    send_pixel(make_pixel(0, 0, 8'h44, 8'h55, 8'h66));
    // A zero width or height keeps nothing.
    set_config(0, 2, 3, 50);
    send_pixel(make_pixel(1, 0, 8'h01, 8'h02, 8'h03));
    send_pixel(make_pixel(0, 0, 8'h04, 8'h05, 8'h06));
    set_config(2, 0, 3, 50);
    send_pixel(make_pixel(1, 0, 8'h07, 8'h08, 8'h09));
    send_pixel(make_pixel(0, 0, 8'h0A, 8'h0B, 8'h0C));
  endtask

  // Reaches the last panel row and column; oversized window registers clip to the store.
  task automatic window_edge_test();
    set_idle(IDLE_RECEIVER);
    set_config(300, (1 << fcb_pkg::PH_W) - 1, 1, 75);
    send_frame(fcb_pkg::MAX_HEIGHT_DEF + 1, 1'b0);
    set_config(fcb_pkg::MAX_WIDTH_DEF, 1, fcb_pkg::MAX_WIDTH_DEF, 25);
    send_frame(fcb_pkg::MAX_WIDTH_DEF, 1'b0);
  endtask

  task automatic backpressure_test();
    set_idle(IDLE_NONE);
    set_config(8, 4, 8, 60);
    stall_req <= ~stall_req;
    send_frame(32, 1'b1);
    drain_results();
    send_frame(32, 1'b0);
  endtask

  task automatic random_fade_test();
    int unsigned pw, ph, srl, ow, n_pix, goal;
    noise_pct = 2;
    for (int phase = 0; phase < 8; phase++) begin
      pw = $urandom_range(1, 12);
      ph = $urandom_range(1, 6);
      srl = pw + $urandom_range(0, 3);
      case ($urandom_range(0, 5))
        0: srl = $urandom_range(1, pw);
        1: begin
          pw = $urandom_range(fcb_pkg::MAX_WIDTH_DEF - 6, (1 << fcb_pkg::PW_W) - 1);
          ph = 1;
          srl = ((pw < fcb_pkg::MAX_WIDTH_DEF) ? pw : fcb_pkg::MAX_WIDTH_DEF)
                + $urandom_range(0, 3);
        end
        default: ;
      endcase
      case ($urandom_range(0, 4))
        0: ow = 0;
        1: ow = fcb_pkg::MIX_MAX;
        2: ow = (1 << fcb_pkg::OW_W) - 1;
        default: ow = $urandom_range(0, (1 << fcb_pkg::OW_W) - 1);
      endcase
      set_config(pw, ph, srl, ow);
      set_idle(idle_mode_t'(phase % 4));
      goal = fade_count + 60;
      while (fade_count < goal) begin
        n_pix = srl * (ph + $urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) n_pix = $urandom_range(1, n_pix);
        send_frame(n_pix, $urandom_range(0, 7) == 0);
      end
    end
    noise_pct = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_test();
    window_edge_test();
    backpressure_test();
    random_fade_test();
    drain_results();
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
